@@ hw/rtl/sump_pump_level_controller_assert.svh @@
// Assertion helpers used by the controller RTL.
`ifndef SUMP_PUMP_LEVEL_CONTROLLER_ASSERT_SVH
`define SUMP_PUMP_LEVEL_CONTROLLER_ASSERT_SVH

// Flag a condition that must never be seen outside reset.
`define SPL_ASSERT_NEVER(lbl, clk_s, rstn_s, expr) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
		else $error("forbidden condition seen");

// Same-cycle implication.
`define SPL_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("implication failed");

// Next-cycle implication.
`define SPL_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

@@ hw/rtl/spl_pkg.sv @@
`default_nettype none
package spl_pkg;

	localparam int SAMPLE_W      = 10;
	localparam int TIME_BITS_DEF = 16;
	localparam int ACC_W         = 32;
	localparam int SCNT_W        = 16;
	localparam int UP_W          = 32;
	localparam int DUTY_W        = 7;
	localparam int REC_T_W       = 16;
	localparam int IN_DATA_W     = 24;
	localparam int OUT_DATA_W    = 80;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	localparam logic [SAMPLE_W-1:0] FILT_RESET   = 10'd1000;
	localparam logic [SAMPLE_W-1:0] THR_RESET    = 10'd900;
	localparam logic [2:0]          SHIFT_RESET  = 3'd3;
	localparam logic [15:0]         STARTUP_RESET = 16'd10;
	localparam logic [15:0]         SPH_RESET    = 16'd3600;
	localparam logic [DUTY_W-1:0]   DUTY_RESET   = 7'd50;
	localparam logic [DUTY_W-1:0]   DUTY_MAX     = 7'd100;
	localparam int                  DUTY_SCALE   = 100;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WET_THR     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILT_SHIFT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_SEC = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEC_PER_HR  = 2'd3;

	typedef struct packed {
		logic [SAMPLE_W-1:0] high;
		logic [SAMPLE_W-1:0] low;
		logic [REC_T_W-1:0]  hours;
		logic [REC_T_W-1:0]  on_s;
		logic [REC_T_W-1:0]  off_s;
	} rec_t;

	typedef struct packed {
		logic              pump_on;
		logic              low_wet;
		logic              high_wet;
		logic [DUTY_W-1:0] duty;
	} stat_t;

	typedef struct packed {
		logic       load;
		logic [1:0] nrec;
	} oq_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILT,
		ST_STOP,
		ST_STOP_WAIT,
		ST_STOP_REC,
		ST_DUTY_WAIT,
		ST_TICK,
		ST_SLOW,
		ST_SLOW_WAIT,
		ST_SHIGH,
		ST_SHIGH_WAIT,
		ST_SREC,
		ST_ACC,
		ST_HOUR_WAIT,
		ST_OUT
	} st_t;

endpackage
`default_nettype wire

@@ hw/rtl/sump_pump_level_controller.sv @@
`default_nettype none
// Sump pump level controller. Each input word carries a low-probe and a
// high-probe sample plus a one-second tick; both samples pass a shift-based
// exponential filter and a filtered value below wet_threshold counts as wet.
// The pump starts when the high probe goes wet and stops once both probes are
// dry. Each word gives one or two result words: a plain status word, or one
// with a report record (tuser high) at every pump stop and once at the
// configured startup second; a stop record comes before a startup record made
// by the same word, and tlast marks the last result of the word. One word is
// worked on at a time: s_tready is high only while the sequencer is idle.
// Divisions run on the single shared restoring divider: the hour check on
// every tick (when seconds_per_hour is non-zero), the idle average and the
// duty figure at a pump stop, and up to two averages at the startup record.
// Results wait in a separate buffer, so the next word is taken while they
// drain. The configuration port is always ready; write it only while the
// block is idle.
`include "sump_pump_level_controller_assert.svh"
module sump_pump_level_controller
	import spl_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// low_sample[9:0], high_sample[9:0], second_tick, three zero bits
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// pump_on, low_wet, high_wet, duty_percent[6:0], rec_high_reading[9:0],
	// rec_low_reading[9:0], rec_hours[15:0], rec_on_seconds[15:0],
	// rec_off_seconds[15:0], two zero bits
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// record_valid
	output logic                       m_tuser,
	output logic                       m_tlast,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// Divider widths: the duty numerator is 100 * on time, the duty divisor
	// is one bit wider than the time counters.
	localparam int DW = (TIME_BITS + 7 > ACC_W) ? TIME_BITS + 7 : ACC_W;
	localparam int VW = (TIME_BITS + 1 > SCNT_W) ? TIME_BITS + 1 : SCNT_W;
	localparam int MW = TIME_BITS + 7;

	// Configuration registers
	logic [SAMPLE_W-1:0] thr_q;
	logic [2:0]          shift_q;
	logic [15:0]         start_sec_q;
	logic [15:0]         sph_q;

	// Sequencer and item registers
	st_t                 state_q, nxt;
	logic [SAMPLE_W-1:0] lo_q, hi_q;
	logic                tick_q;
	logic [1:0]          nrec_q;
	rec_t                rec0_q, rec1_q;

	// Controller state
	logic [SAMPLE_W-1:0]  low_filt_q, high_filt_q;
	logic                 low_wet_q, high_wet_q;
	logic                 running_q, idle_seen_q, startup_sent_q;
	logic [TIME_BITS-1:0] on_cnt_q, off_cnt_q, prev_on_q, prev_off_q, hours_q;
	logic [ACC_W-1:0]     low_acc_q, high_acc_q;
	logic [SCNT_W-1:0]    low_n_q, high_n_q;
	logic [SAMPLE_W-1:0]  held_high_q, held_low_q;
	logic [UP_W-1:0]      uptime_q;
	logic [DUTY_W-1:0]    duty_q;

	// Shared divider
	logic          div_start;
	logic [DW-1:0] div_dnd;
	logic [VW-1:0] div_dvs;
	div_stat_t     div_st;
	logic [DW-1:0] div_quo;
	logic [VW-1:0] div_rem;

	logic [SAMPLE_W-1:0]  lf_new, hf_new;
	logic                 lw_new, hw_new;
	logic [SAMPLE_W-1:0]  avg_sat;
	logic [TIME_BITS:0]   duty_sum;
	logic [MW-1:0]        duty_num;
	logic [UP_W-1:0]      up_next;
	logic [TIME_BITS+15:0] hrs_ext, on_ext, off_ext;
	rec_t                 stop_rec, start_rec;
	oq_ctl_t              oq_ctl;
	stat_t                oq_stat;
	logic                 oq_free;

	// Filter: new = sample >> k + (prev - prev >> k), kept to sample width
	assign lf_new = SAMPLE_W'((lo_q >> shift_q) + (low_filt_q - (low_filt_q >> shift_q)));
	assign hf_new = SAMPLE_W'((hi_q >> shift_q) + (high_filt_q - (high_filt_q >> shift_q)));
	assign lw_new = lf_new < thr_q;
	assign hw_new = hf_new < thr_q;

	// Clamp an average to the largest sample value
	assign avg_sat = (|div_quo[DW-1:SAMPLE_W]) ? '1 : div_quo[SAMPLE_W-1:0];

	assign duty_sum = {1'b0, prev_on_q} + {1'b0, prev_off_q};
	assign duty_num = MW'(prev_on_q) * MW'(DUTY_SCALE);
	assign up_next  = uptime_q + UP_W'(1);

	// Fit the time counters to the 16-bit record fields
	assign hrs_ext = {16'b0, hours_q};
	assign on_ext  = {16'b0, prev_on_q};
	assign off_ext = {16'b0, prev_off_q};

	assign stop_rec.high  = held_high_q;
	assign stop_rec.low   = held_low_q;
	assign stop_rec.hours = hrs_ext[15:0];
	assign stop_rec.on_s  = on_ext[15:0];
	assign stop_rec.off_s = off_ext[15:0];

	assign start_rec.high  = held_high_q;
	assign start_rec.low   = held_low_q;
	assign start_rec.hours = hrs_ext[15:0];
	assign start_rec.on_s  = '0;
	assign start_rec.off_s = '0;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			shift_q     <= SHIFT_RESET;
			start_sec_q <= STARTUP_RESET;
			sph_q       <= SPH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WET_THR:     thr_q       <= cfg_data[SAMPLE_W-1:0];
				CFG_FILT_SHIFT:  shift_q     <= cfg_data[2:0];
				CFG_STARTUP_SEC: start_sec_q <= cfg_data;
				CFG_SEC_PER_HR:  sph_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

	// Next state, divider requests and buffer load
	always_comb begin
		nxt         = state_q;
		div_start   = 1'b0;
		div_dnd     = DW'(low_acc_q);
		div_dvs     = VW'(low_n_q);
		oq_ctl.load = 1'b0;
		oq_ctl.nrec = nrec_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					nxt = ST_FILT;
				end
			end
			ST_FILT: begin
				// Stop only when both probes are dry and the pump runs
				if (!hw_new && !lw_new && running_q) begin
					nxt = ST_STOP;
				end else begin
					nxt = ST_TICK;
				end
			end
			ST_STOP: begin
				if (low_n_q != '0) begin
					div_start = 1'b1;
					nxt       = ST_STOP_WAIT;
				end else begin
					nxt = ST_STOP_REC;
				end
			end
			ST_STOP_WAIT: begin
				if (div_st.done) begin
					nxt = ST_STOP_REC;
				end
			end
			ST_STOP_REC: begin
				div_dnd = DW'(duty_num);
				div_dvs = VW'(duty_sum);
				if (duty_sum != '0) begin
					div_start = 1'b1;
					nxt       = ST_DUTY_WAIT;
				end else begin
					nxt = ST_TICK;
				end
			end
			ST_DUTY_WAIT: begin
				if (div_st.done) begin
					nxt = ST_TICK;
				end
			end
			ST_TICK: begin
				if (!tick_q) begin
					nxt = ST_OUT;
				end else if (up_next == UP_W'(start_sec_q) && !startup_sent_q) begin
					nxt = ST_SLOW;
				end else begin
					nxt = ST_ACC;
				end
			end
			ST_SLOW: begin
				if (low_n_q != '0) begin
					div_start = 1'b1;
					nxt       = ST_SLOW_WAIT;
				end else begin
					nxt = ST_SHIGH;
				end
			end
			ST_SLOW_WAIT: begin
				if (div_st.done) begin
					nxt = ST_SHIGH;
				end
			end
			ST_SHIGH: begin
				div_dnd = DW'(high_acc_q);
				div_dvs = VW'(high_n_q);
				if (high_n_q != '0) begin
					div_start = 1'b1;
					nxt       = ST_SHIGH_WAIT;
				end else begin
					nxt = ST_SREC;
				end
			end
			ST_SHIGH_WAIT: begin
				if (div_st.done) begin
					nxt = ST_SREC;
				end
			end
			ST_SREC: begin
				nxt = ST_ACC;
			end
			ST_ACC: begin
				// Hour check: uptime modulo seconds_per_hour
				div_dnd = DW'(up_next - UP_W'(1));
				div_dvs = VW'(sph_q);
				if (sph_q != '0) begin
					div_start = 1'b1;
					nxt       = ST_HOUR_WAIT;
				end else begin
					nxt = ST_OUT;
				end
			end
			ST_HOUR_WAIT: begin
				if (div_st.done) begin
					nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (oq_free) begin
					oq_ctl.load = 1'b1;
					nxt         = ST_IDLE;
				end
			end
			default: nxt = ST_IDLE;
		endcase
	end

	// Item registers and records; no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			lo_q   <= s_tdata[SAMPLE_W-1:0];
			hi_q   <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
			tick_q <= s_tdata[2*SAMPLE_W];
		end
		if (state_q == ST_STOP_REC) begin
			rec0_q <= stop_rec;
		end
		if (state_q == ST_SREC) begin
			if (nrec_q == 2'd0) begin
				rec0_q <= start_rec;
			end else begin
				rec1_q <= start_rec;
			end
		end
	end

	// Controller state updates, step by step in model order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrec_q         <= 2'd0;
			low_filt_q     <= FILT_RESET;
			high_filt_q    <= FILT_RESET;
			low_wet_q      <= 1'b0;
			high_wet_q     <= 1'b0;
			running_q      <= 1'b0;
			idle_seen_q    <= 1'b0;
			startup_sent_q <= 1'b0;
			on_cnt_q       <= '0;
			off_cnt_q      <= '0;
			prev_on_q      <= '0;
			prev_off_q     <= '0;
			hours_q        <= '0;
			low_acc_q      <= '0;
			high_acc_q     <= '0;
			low_n_q        <= '0;
			high_n_q       <= '0;
			held_high_q    <= '0;
			held_low_q     <= '0;
			uptime_q       <= '0;
			duty_q         <= DUTY_RESET;
		end else begin
			unique case (state_q) inside
				ST_IDLE: begin
					if (s_tvalid) begin
						nrec_q <= 2'd0;
					end
				end
				ST_FILT: begin
					low_filt_q  <= lf_new;
					high_filt_q <= hf_new;
					low_wet_q   <= lw_new;
					high_wet_q  <= hw_new;
					if (hw_new) begin
						if (!running_q) begin
							// Capture the raw high sample at pump start
							held_high_q <= hi_q;
							running_q   <= 1'b1;
						end
					end else if (!lw_new) begin
						running_q <= 1'b0;
					end
				end
				ST_STOP: begin
					prev_on_q <= on_cnt_q;
					on_cnt_q  <= '0;
				end
				ST_STOP_WAIT, ST_SLOW_WAIT: begin
					if (div_st.done) begin
						held_low_q <= avg_sat;
					end
				end
				ST_STOP_REC: begin
					nrec_q    <= 2'd1;
					low_acc_q <= '0;
					low_n_q   <= '0;
				end
				ST_DUTY_WAIT: begin
					if (div_st.done) begin
						duty_q <= div_quo[DUTY_W-1:0];
					end
				end
				ST_TICK: begin
					if (tick_q) begin
						uptime_q <= up_next;
					end
				end
				ST_SHIGH_WAIT: begin
					if (div_st.done) begin
						held_high_q <= avg_sat;
					end
				end
				ST_SREC: begin
					nrec_q         <= nrec_q + 2'd1;
					startup_sent_q <= 1'b1;
				end
				ST_ACC: begin
					if (running_q) begin
						high_acc_q <= high_acc_q + ACC_W'(hi_q);
						high_n_q   <= high_n_q + SCNT_W'(1);
						on_cnt_q   <= on_cnt_q + TIME_BITS'(1);
						// Close a pending idle period
						if (idle_seen_q) begin
							prev_off_q  <= off_cnt_q;
							off_cnt_q   <= '0;
							idle_seen_q <= 1'b0;
						end
					end else begin
						low_acc_q   <= low_acc_q + ACC_W'(lo_q);
						low_n_q     <= low_n_q + SCNT_W'(1);
						off_cnt_q   <= off_cnt_q + TIME_BITS'(1);
						idle_seen_q <= 1'b1;
					end
				end
				ST_HOUR_WAIT: begin
					if (div_st.done && div_rem == '0) begin
						hours_q <= hours_q + TIME_BITS'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign oq_stat.pump_on  = running_q;
	assign oq_stat.low_wet  = low_wet_q;
	assign oq_stat.high_wet = high_wet_q;
	assign oq_stat.duty     = duty_q;

	spl_div #(
		.DW(DW),
		.VW(VW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dnd),
		.divisor   (div_dvs),
		.status    (div_st),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	spl_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (oq_ctl),
		.stat_in  (oq_stat),
		.rec0_in  (rec0_q),
		.rec1_in  (rec1_q),
		.free     (oq_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Never restart the divider while it still iterates
	`SPL_ASSERT_NEVER(a_div_no_restart, clk, arst_n, div_start && div_st.busy)
	// Duty stays a percentage
	`SPL_ASSERT_NEVER(a_duty_range, clk, arst_n, duty_q > DUTY_MAX)
	// A word without a record is always the last of its item
	`SPL_ASSERT_IMPL(a_plain_is_last, clk, arst_n, m_tvalid && !m_tuser, m_tlast)
	// The first of two words is followed by a last word carrying a record
	`SPL_ASSERT_NEXT(a_pair_follows, clk, arst_n, m_tvalid && m_tready && !m_tlast,
		m_tvalid && m_tlast && m_tuser)

endmodule
`default_nettype wire

@@ hw/rtl/spl_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module spl_div
	import spl_pkg::*;
#(
	parameter int DW = 32,
	parameter int VW = 17
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output div_stat_t          status,
	output logic [DW-1:0]      quotient,
	output logic [VW-1:0]      remainder
);

	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   shifted;
	logic [VW+1:0] diff;
	logic          ge;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = !diff[VW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW-1:0] : shifted[VW-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;
	assign remainder   = rem_q;

endmodule
`default_nettype wire

@@ hw/rtl/spl_outq.sv @@
`default_nettype none
// Result buffer: holds one or two words of an item and drains them.
module spl_outq
	import spl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire oq_ctl_t               ctl,
	input  wire stat_t                 stat_in,
	input  wire rec_t                  rec0_in,
	input  wire rec_t                  rec1_in,
	output logic                       free,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// pump_on, low_wet, high_wet, duty_percent[6:0], rec_high_reading[9:0],
	// rec_low_reading[9:0], rec_hours[15:0], rec_on_seconds[15:0],
	// rec_off_seconds[15:0], two zero bits
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// record_valid
	output logic                       m_tuser,
	output logic                       m_tlast
);

	logic  full_q;
	logic  idx_q;
	logic  two_q;
	logic  rv0_q;
	stat_t stat_q;
	rec_t  rec0_q;
	rec_t  rec1_q;
	rec_t  cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= 1'b0;
			two_q  <= 1'b0;
			rv0_q  <= 1'b0;
		end else if (ctl.load && !full_q) begin
			full_q <= 1'b1;
			idx_q  <= 1'b0;
			two_q  <= (ctl.nrec == 2'd2);
			rv0_q  <= (ctl.nrec != 2'd0);
		end else if (full_q && m_tready) begin
			if (m_tlast) begin
				full_q <= 1'b0;
				idx_q  <= 1'b0;
			end else begin
				idx_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && !full_q) begin
			stat_q <= stat_in;
			rec0_q <= (ctl.nrec == 2'd0) ? '0 : rec0_in;
			rec1_q <= rec1_in;
		end
	end

	assign cur      = idx_q ? rec1_q : rec0_q;
	assign free     = !full_q;
	assign m_tvalid = full_q;
	assign m_tuser  = idx_q | rv0_q;
	assign m_tlast  = idx_q | !two_q;
	assign m_tdata  = {2'b00, cur.off_s, cur.on_s, cur.hours, cur.low, cur.high,
		stat_q.duty, stat_q.high_wet, stat_q.low_wet, stat_q.pump_on};

endmodule
`default_nettype wire
